/* rtl/core/hrhp_pkg.sv */
// package: codes, types and character classes for the http request head parser
`timescale 1ns / 1ps

package hrhp_pkg;

  localparam int unsigned StateW = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TagW = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned VerW = 8;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned InDataW = 8;

  // parse state codes
  localparam logic [StateW-1:0] ST_METHOD_START  = 5'd0;
  localparam logic [StateW-1:0] ST_METHOD        = 5'd1;
  localparam logic [StateW-1:0] ST_URI           = 5'd2;
  localparam logic [StateW-1:0] ST_VER_H         = 5'd3;
  localparam logic [StateW-1:0] ST_VER_T1        = 5'd4;
  localparam logic [StateW-1:0] ST_VER_T2        = 5'd5;
  localparam logic [StateW-1:0] ST_VER_P         = 5'd6;
  localparam logic [StateW-1:0] ST_VER_SLASH     = 5'd7;
  localparam logic [StateW-1:0] ST_MAJOR_START   = 5'd8;
  localparam logic [StateW-1:0] ST_MAJOR         = 5'd9;
  localparam logic [StateW-1:0] ST_MINOR_START   = 5'd10;
  localparam logic [StateW-1:0] ST_MINOR         = 5'd11;
  localparam logic [StateW-1:0] ST_LF_1          = 5'd12;
  localparam logic [StateW-1:0] ST_LINE_START    = 5'd13;
  localparam logic [StateW-1:0] ST_LWS           = 5'd14;
  localparam logic [StateW-1:0] ST_NAME          = 5'd15;
  localparam logic [StateW-1:0] ST_SP_BEFORE_VAL = 5'd16;
  localparam logic [StateW-1:0] ST_VALUE         = 5'd17;
  localparam logic [StateW-1:0] ST_LF_2          = 5'd18;
  localparam logic [StateW-1:0] ST_LF_3          = 5'd19;

  typedef enum logic [StatusW-1:0] {
    STATUS_MORE = 2'd0,
    STATUS_DONE = 2'd1,
    STATUS_ERR  = 2'd2
  } status_e;

  typedef enum logic [TagW-1:0] {
    TAG_NONE    = 3'd0,
    TAG_METHOD  = 3'd1,
    TAG_URI     = 3'd2,
    TAG_NEWNAME = 3'd3,
    TAG_NAME    = 3'd4,
    TAG_VALUE   = 3'd5
  } tag_e;

  localparam logic [ByteW-1:0] CH_HT    = 8'h09;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0a;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0d;
  localparam logic [ByteW-1:0] CH_SP    = 8'h20;
  localparam logic [ByteW-1:0] CH_DOT   = 8'h2e;
  localparam logic [ByteW-1:0] CH_SLASH = 8'h2f;
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;
  localparam logic [ByteW-1:0] CH_COLON = 8'h3a;
  localparam logic [ByteW-1:0] CH_H     = 8'h48;
  localparam logic [ByteW-1:0] CH_P     = 8'h50;
  localparam logic [ByteW-1:0] CH_T     = 8'h54;
  localparam logic [ByteW-1:0] CH_MAXCHAR = 8'd127;
  localparam logic [ByteW-1:0] CH_MAXCTL  = 8'd31;
  localparam logic [VerW-1:0]  VER_MAX    = 8'd255;

  typedef struct packed {
    logic [StateW-1:0] state;
    logic              header_seen;
    logic [VerW-1:0]   major;
    logic [VerW-1:0]   minor;
  } parse_t;

  typedef struct packed {
    status_e          status;
    tag_e             tag;
    logic [ByteW-1:0] data;
    logic [VerW-1:0]  major;
    logic [VerW-1:0]  minor;
  } result_t;

  function automatic logic is_ctl(input logic [ByteW-1:0] c);
    return (c <= CH_MAXCTL) || (c == CH_MAXCHAR);
  endfunction

  function automatic logic is_dec_char(input logic [ByteW-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_special(input logic [ByteW-1:0] c);
    logic r;
    case (c)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [ByteW-1:0] c);
    return (c <= CH_MAXCHAR) && !is_ctl(c) && !is_special(c);
  endfunction

  // v*10 + digit, saturating
  function automatic logic [VerW-1:0] acc_digit(input logic [VerW-1:0] v,
                                                input logic [ByteW-1:0] c);
    logic [VerW+3:0] sum;
    sum = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {4'd0, (c - CH_ZERO)};
    return (sum > {4'd0, VER_MAX}) ? VER_MAX : sum[VerW-1:0];
  endfunction

endpackage

/* rtl/core/hrhp_step.sv */
// next-state and result logic for one byte of the request head
`timescale 1ns / 1ps

module hrhp_step (
  input  hrhp_pkg::parse_t            cur_i,
  input  logic                        restart_i,
  input  logic [hrhp_pkg::ByteW-1:0]  byte_i,
  output hrhp_pkg::parse_t            nxt_o,
  output hrhp_pkg::result_t           res_o
);
  import hrhp_pkg::*;

  logic              err;
  logic              done;
  tag_e              tag;
  parse_t            upd;
  logic              is_ws;

  assign is_ws = (byte_i == CH_SP) || (byte_i == CH_HT);

  always_comb begin
    err  = 1'b0;
    done = 1'b0;
    tag  = TAG_NONE;
    upd  = cur_i;
    case (cur_i.state)
      ST_METHOD_START: begin
        if (is_token(byte_i)) begin
          upd.state = ST_METHOD;
          tag = TAG_METHOD;
        end else err = 1'b1;
      end
      ST_METHOD: begin
        if (byte_i == CH_SP) upd.state = ST_URI;
        else if (is_token(byte_i)) tag = TAG_METHOD;
        else err = 1'b1;
      end
      ST_URI: begin
        if (byte_i == CH_SP) upd.state = ST_VER_H;
        else if (is_ctl(byte_i)) err = 1'b1;
        else tag = TAG_URI;
      end
      ST_VER_H: begin
        if (byte_i == CH_H) upd.state = ST_VER_T1;
        else err = 1'b1;
      end
      ST_VER_T1: begin
        if (byte_i == CH_T) upd.state = ST_VER_T2;
        else err = 1'b1;
      end
      ST_VER_T2: begin
        if (byte_i == CH_T) upd.state = ST_VER_P;
        else err = 1'b1;
      end
      ST_VER_P: begin
        if (byte_i == CH_P) upd.state = ST_VER_SLASH;
        else err = 1'b1;
      end
      ST_VER_SLASH: begin
        if (byte_i == CH_SLASH) begin
          upd.major = '0;
          upd.minor = '0;
          upd.state = ST_MAJOR_START;
        end else err = 1'b1;
      end
      ST_MAJOR_START: begin
        if (is_dec_char(byte_i)) begin
          upd.major = acc_digit(cur_i.major, byte_i);
          upd.state = ST_MAJOR;
        end else err = 1'b1;
      end
      ST_MAJOR: begin
        if (byte_i == CH_DOT) upd.state = ST_MINOR_START;
        else if (is_dec_char(byte_i)) upd.major = acc_digit(cur_i.major, byte_i);
        else err = 1'b1;
      end
      ST_MINOR_START: begin
        if (is_dec_char(byte_i)) begin
          upd.minor = acc_digit(cur_i.minor, byte_i);
          upd.state = ST_MINOR;
        end else err = 1'b1;
      end
      ST_MINOR: begin
        if (byte_i == CH_CR) upd.state = ST_LF_1;
        else if (is_dec_char(byte_i)) upd.minor = acc_digit(cur_i.minor, byte_i);
        else err = 1'b1;
      end
      ST_LF_1: begin
        if (byte_i == CH_LF) upd.state = ST_LINE_START;
        else err = 1'b1;
      end
      ST_LINE_START: begin
        if (byte_i == CH_CR) upd.state = ST_LF_3;
        else if (cur_i.header_seen && is_ws) upd.state = ST_LWS;
        else if (is_token(byte_i)) begin
          upd.header_seen = 1'b1;
          upd.state = ST_NAME;
          tag = TAG_NEWNAME;
        end else err = 1'b1;
      end
      ST_LWS: begin
        if (byte_i == CH_CR) upd.state = ST_LF_2;
        else if (is_ws) upd.state = ST_LWS;
        else if (is_ctl(byte_i)) err = 1'b1;
        else begin
          upd.state = ST_VALUE;
          tag = TAG_VALUE;
        end
      end
      ST_NAME: begin
        if (byte_i == CH_COLON) upd.state = ST_SP_BEFORE_VAL;
        else if (is_token(byte_i)) tag = TAG_NAME;
        else err = 1'b1;
      end
      ST_SP_BEFORE_VAL: begin
        if (byte_i == CH_SP) upd.state = ST_VALUE;
        else err = 1'b1;
      end
      ST_VALUE: begin
        if (byte_i == CH_CR) upd.state = ST_LF_2;
        else if (is_ctl(byte_i)) err = 1'b1;
        else tag = TAG_VALUE;
      end
      ST_LF_2: begin
        if (byte_i == CH_LF) upd.state = ST_LINE_START;
        else err = 1'b1;
      end
      ST_LF_3: begin
        if (byte_i == CH_LF) done = 1'b1;
        else err = 1'b1;
      end
      default: err = 1'b1;
    endcase
  end

  always_comb begin
    if (restart_i) begin
      nxt_o        = '{state: ST_METHOD_START, header_seen: 1'b0, major: '0, minor: '0};
      res_o.status = STATUS_MORE;
      res_o.tag    = TAG_NONE;
      res_o.data   = '0;
    end else if (err) begin
      nxt_o        = cur_i;
      res_o.status = STATUS_ERR;
      res_o.tag    = TAG_NONE;
      res_o.data   = byte_i;
    end else begin
      nxt_o        = upd;
      res_o.status = done ? STATUS_DONE : STATUS_MORE;
      res_o.tag    = tag;
      res_o.data   = byte_i;
    end
    res_o.major = nxt_o.major;
    res_o.minor = nxt_o.minor;
  end

endmodule

/* rtl/core/http_request_head_parser.sv */
// top level: http request head parser, one byte per cycle unless the result stalls
//
//  channel  | dir | payload
//  s_axis   | in  | tdata: in_byte[7:0]; tuser: func (1 = restart)
//  m_axis   | out | tdata: status[1:0] byte_tag[4:2] out_byte[12:5]
//           |     |        version_major[20:13] version_minor[28:21], rest zero
//
//  one byte per cycle sustained while the result is not stalled; path from
//  input transfer to result: one input register, then the parse logic, then the result register
//  parse state updates when the byte moves into the result register
//  rst_ni clears the parse state and both valid flags
//  a stalled result holds both stages; the input side stays ready while
//  the input register is empty
`timescale 1ns / 1ps

module http_request_head_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hrhp_pkg::InDataW-1:0]    s_axis_tdata,   // in_byte
  input  logic                            s_axis_tuser,   // func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [hrhp_pkg::OutDataW-1:0]   m_axis_tdata    // status, byte_tag, out_byte,
                                                          // version_major, version_minor
);
  import hrhp_pkg::*;

  logic              in_valid_q;
  logic              in_func_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_valid_q;
  result_t           res_q;
  result_t           res_d;
  parse_t            parse_q;
  parse_t            parse_d;
  logic              advance;
  logic              s_xfer;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  hrhp_step u_step (
    .cur_i     (parse_q),
    .restart_i (in_func_q),
    .byte_i    (in_byte_q),
    .nxt_o     (parse_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_func_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      parse_q     <= '{state: ST_METHOD_START, header_seen: 1'b0, major: '0, minor: '0};
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        parse_q <= parse_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, res_q.minor, res_q.major, res_q.data, res_q.tag, res_q.status};

  // assertions
  a_err_untagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status == STATUS_ERR) |-> (res_q.tag == TAG_NONE))
    else $error("error result carries a tag");

  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_q.state <= ST_LF_3)
    else $error("parse state out of range");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && in_func_q |=>
      (parse_q.state == ST_METHOD_START) && !parse_q.header_seen &&
      (parse_q.major == '0) && (parse_q.minor == '0))
    else $error("restart did not clear parse state");

  a_done_in_lf3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status == STATUS_DONE) |-> (parse_q.state == ST_LF_3))
    else $error("complete head outside final line feed state");

  a_err_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && !in_func_q && (res_d.status == STATUS_ERR) |=>
      (parse_q == $past(parse_q)))
    else $error("error changed parse state");

  a_versions_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q |=>
      (res_q.major == parse_q.major) && (res_q.minor == parse_q.minor))
    else $error("result versions differ from parse state");

endmodule
